// ----- hdl/blh_pkg.sv -----
`default_nettype none

package blh_pkg;

    // field and register widths
    localparam int COORD_W  = 32;
    localparam int FUNC_W   = 2;
    localparam int BIN_IDX_W = 8;
    localparam int COUNT_W  = 32;
    localparam int SUM_W    = 64;
    localparam int BOND_W   = 40;
    localparam int FRAME_W  = 32;
    localparam int BPC_W    = 13;
    localparam int CPF_W    = 16;
    localparam int BEAD_W   = 12;
    localparam int CHAIN_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // shared multiplier
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    // bin index is floor(r2 * 100) with r2 in q32
    localparam int BIN_W = 40;
    localparam logic [MUL_W-1:0] BIN_SCALE = MUL_W'(100);

    // chain geometry limits
    localparam logic [BPC_W-1:0] BPC_MIN = BPC_W'(2);
    localparam logic [BPC_W-1:0] BPC_MAX = BPC_W'(4096);

    // request function codes
    localparam logic [FUNC_W-1:0] FUNC_BEAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BEADS_PER_CHAIN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAINS_PER_FRAME = 1'b1;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_ACC,
        ST_SCALE,
        ST_BIN_HI,
        ST_BIN_LO,
        ST_BIN_SUM,
        ST_INC_RD,
        ST_INC_WR,
        ST_LOOKUP,
        ST_WIPE,
        ST_DONE
    } blh_state_t;

endpackage

`default_nettype wire

// ----- hdl/bond_length_histogram.sv -----
`default_nettype none

// channel   | handshake          | payload
// ----------+--------------------+---------------------------------------------------
// request   | s_valid / s_ready  | s_func, s_pos_x, s_pos_y, s_pos_z, s_bin_index
// result    | m_valid / m_ready  | m_bin_count, m_sum_sq_length, m_bond_total,
//           |                    | m_frame_total
// config    | cfg_we             | cfg_index, cfg_data (no wait, no read-back)
//
// one request at a time; s_ready is high only while the sequencer is idle
// a bead that closes a bond runs these steps from acceptance to ready again:
//   three passes of difference, square and accumulate through the one shared
//   multiplier, scaling, two multiplies by 100 for the bin index,
//   then a read-modify-write of the histogram memory
// a bead that opens a chain and an unused code go straight to the final state; a read looks up first
// clear and reset both sweep the histogram memory, one bin a cycle,
//   and s_ready stays low during the sweep (config writes still land)
// the result sits in an output register; if it is not taken the sequencer
//   holds in its final state until the register frees up
// aresetn is synchronous and active low

module bond_length_histogram
    import blh_pkg::*;
#(
    parameter int BIN_COUNT       = 201,
    parameter int COORD_FRAC_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [FUNC_W-1:0]      s_func,
    input  wire logic signed [COORD_W-1:0] s_pos_x,
    input  wire logic signed [COORD_W-1:0] s_pos_y,
    input  wire logic signed [COORD_W-1:0] s_pos_z,
    input  wire logic [BIN_IDX_W-1:0]   s_bin_index,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [COUNT_W-1:0]          m_bin_count,
    output logic [SUM_W-1:0]            m_sum_sq_length,
    output logic [BOND_W-1:0]           m_bond_total,
    output logic [FRAME_W-1:0]          m_frame_total
);

    localparam int ADDR_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BIN_COUNT - 1);
    localparam logic [BIN_W-1:0]  BIN_LIMIT = BIN_W'(BIN_COUNT);
    localparam logic [31:0]       IDX_LIMIT = 32'(BIN_COUNT);

    // fixed point: a product of two coordinates has twice their fraction bits
    localparam int FB2 = 2 * COORD_FRAC_BITS;
    localparam int SHR = (FB2 >= 32) ? FB2 - 32 : 0;
    localparam int SHL = (FB2 < 32) ? 32 - FB2 : 0;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // saturating 64-bit add
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    // rescale a sum of squares to 32 fraction bits, saturating on left shift
    function automatic logic [SUM_W-1:0] to_q32(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] lim;
        lim = {SUM_W{1'b1}} >> SHL;
        if (FB2 >= 32) begin
            return s >> SHR;
        end else if (s > lim) begin
            return '1;
        end else begin
            return s << SHL;
        end
    endfunction

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    blh_state_t state_reg, state_next;

    logic [BPC_W-1:0]   bpc_reg, bpc_next;
    logic [CPF_W-1:0]   cpf_reg, cpf_next;

    logic [BEAD_W-1:0]  bead_reg, bead_next;
    logic [CHAIN_W-1:0] chain_reg, chain_next;
    logic [COORD_W-1:0] prev_x_reg, prev_x_next;
    logic [COORD_W-1:0] prev_y_reg, prev_y_next;
    logic [COORD_W-1:0] prev_z_reg, prev_z_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [BOND_W-1:0]  bond_reg, bond_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [1:0]         axis_reg, axis_next;
    logic               look_hit_reg, look_hit_next;
    logic               hit_reg, hit_next;

    // working payload
    logic [COORD_W-1:0] cur_x_reg, cur_x_next;
    logic [COORD_W-1:0] cur_y_reg, cur_y_next;
    logic [COORD_W-1:0] cur_z_reg, cur_z_next;
    logic [MUL_W-1:0]   mag_reg, mag_next;
    logic [SUM_W-1:0]   acc_reg, acc_next;
    logic [SUM_W-1:0]   r2_reg, r2_next;
    logic [BIN_W-1:0]   bin_hi_reg, bin_hi_next;
    logic [BIN_W-1:0]   bin_reg, bin_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0] m_bin_count_reg, m_bin_count_next;
    logic [SUM_W-1:0]   m_sum_reg, m_sum_next;
    logic [BOND_W-1:0]  m_bond_reg, m_bond_next;
    logic [FRAME_W-1:0] m_frame_reg, m_frame_next;

    // ------------------------------------------------------------------
    // shared multiplier and histogram memory
    // ------------------------------------------------------------------
    logic               mul_en;
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [PROD_W-1:0]  product;

    logic               hist_we;
    logic [ADDR_W-1:0]  hist_waddr;
    logic [COUNT_W-1:0] hist_wdata;
    logic               hist_re;
    logic [ADDR_W-1:0]  hist_raddr;
    logic [COUNT_W-1:0] hist_rdata;

    blh_mul u_mul (
        .aclk    (aclk),
        .en      (mul_en),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (product)
    );

    blh_hist_ram #(
        .DEPTH  (BIN_COUNT),
        .ADDR_W (ADDR_W),
        .DATA_W (COUNT_W)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (hist_we),
        .wr_addr (hist_waddr),
        .wr_data (hist_wdata),
        .rd_en   (hist_re),
        .rd_addr (hist_raddr),
        .rd_data (hist_rdata)
    );

    // ------------------------------------------------------------------
    // chain and frame position of an incoming bead
    // ------------------------------------------------------------------
    logic [BPC_W-1:0]   bpc_eff;
    logic [CPF_W-1:0]   cpf_eff;
    logic [BPC_W-1:0]   pos_bead;
    logic [CHAIN_W:0]   pos_chain;
    logic [BPC_W-1:0]   end_bead;
    logic [CHAIN_W:0]   end_chain;
    logic               pos_first;
    logic               pos_bond;

    always_comb begin
        // out-of-range registers act as the nearest legal value
        if (bpc_reg < BPC_MIN) begin
            bpc_eff = BPC_MIN;
        end else if (bpc_reg > BPC_MAX) begin
            bpc_eff = BPC_MAX;
        end else begin
            bpc_eff = bpc_reg;
        end
        cpf_eff = (cpf_reg == '0) ? CPF_W'(1) : cpf_reg;

        // a counter left stale by a register write wraps first
        pos_bead  = {1'b0, bead_reg};
        pos_chain = {1'b0, chain_reg};
        if (pos_bead >= bpc_eff) begin
            pos_bead  = '0;
            pos_chain = pos_chain + 1'b1;
        end
        if (pos_chain >= {1'b0, cpf_eff}) begin
            pos_chain = '0;
        end
        pos_first = (pos_bead == '0) && (pos_chain == '0);
        pos_bond  = (pos_bead != '0);

        // advance past this bead
        end_bead  = pos_bead + 1'b1;
        end_chain = pos_chain;
        if (end_bead >= bpc_eff) begin
            end_bead  = '0;
            end_chain = pos_chain + 1'b1;
            if (end_chain >= {1'b0, cpf_eff}) begin
                end_chain = '0;
            end
        end
    end

    logic out_free;
    logic clr_last;
    logic rd_sat;

    assign out_free = !m_valid_reg || m_ready;
    assign clr_last = (clr_addr_reg == LAST_ADDR);
    assign rd_sat   = (hist_rdata == '1);

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_func)
                        FUNC_BEAD:  state_next = pos_bond ? ST_DIFF : ST_DONE;
                        FUNC_READ:  state_next = ST_LOOKUP;
                        FUNC_CLEAR: state_next = ST_WIPE;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_DIFF:    state_next = ST_MUL;
            ST_MUL:     state_next = ST_ACC;
            ST_ACC:     state_next = (axis_reg == AXIS_Z) ? ST_SCALE : ST_DIFF;
            ST_SCALE:   state_next = ST_BIN_HI;
            ST_BIN_HI:  state_next = ST_BIN_LO;
            ST_BIN_LO:  state_next = ST_BIN_SUM;
            ST_BIN_SUM: state_next = ST_INC_RD;
            ST_INC_RD:  state_next = ST_INC_WR;
            ST_INC_WR:  state_next = ST_DONE;
            ST_LOOKUP:  state_next = ST_DONE;
            ST_WIPE: begin
                if (clr_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_INIT;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: unit and memory controls
    // ------------------------------------------------------------------
    always_comb begin
        s_ready    = 1'b0;
        mul_en     = 1'b0;
        mul_a      = mag_reg;
        mul_b      = mag_reg;
        hist_we    = 1'b0;
        hist_waddr = bin_reg[ADDR_W-1:0];
        hist_wdata = rd_sat ? hist_rdata : hist_rdata + 1'b1;
        hist_re    = 1'b0;
        hist_raddr = bin_reg[ADDR_W-1:0];
        unique case (state_reg)
            ST_INIT, ST_WIPE: begin
                hist_we    = 1'b1;
                hist_waddr = clr_addr_reg;
                hist_wdata = '0;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_MUL: begin
                mul_en = 1'b1;
            end
            ST_BIN_HI: begin
                mul_en = 1'b1;
                mul_a  = r2_reg[SUM_W-1:MUL_W];
                mul_b  = BIN_SCALE;
            end
            ST_BIN_LO: begin
                mul_en = 1'b1;
                mul_a  = r2_reg[MUL_W-1:0];
                mul_b  = BIN_SCALE;
            end
            ST_INC_RD: begin
                hist_re = 1'b1;
            end
            ST_INC_WR: begin
                hist_we = hit_reg;
            end
            ST_LOOKUP: begin
                hist_re    = 1'b1;
                hist_raddr = addr_reg;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // datapath next values
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] sel_cur;
    logic [COORD_W-1:0] sel_prev;
    logic [COORD_W:0]   d_cp;
    logic [COORD_W:0]   d_pc;
    logic [31:0]        idx_wide;

    always_comb begin
        case (axis_reg)
            AXIS_X: begin
                sel_cur  = cur_x_reg;
                sel_prev = prev_x_reg;
            end
            AXIS_Y: begin
                sel_cur  = cur_y_reg;
                sel_prev = prev_y_reg;
            end
            default: begin
                sel_cur  = cur_z_reg;
                sel_prev = prev_z_reg;
            end
        endcase
        // both differences side by side, the sign picks the magnitude
        d_cp = {sel_cur[COORD_W-1], sel_cur} - {sel_prev[COORD_W-1], sel_prev};
        d_pc = {sel_prev[COORD_W-1], sel_prev} - {sel_cur[COORD_W-1], sel_cur};
    end

    assign idx_wide = 32'(s_bin_index);

    always_comb begin
        bpc_next         = bpc_reg;
        cpf_next         = cpf_reg;
        bead_next        = bead_reg;
        chain_next       = chain_reg;
        prev_x_next      = prev_x_reg;
        prev_y_next      = prev_y_reg;
        prev_z_next      = prev_z_reg;
        sum_next         = sum_reg;
        bond_next        = bond_reg;
        frame_next       = frame_reg;
        clr_addr_next    = clr_addr_reg;
        axis_next        = axis_reg;
        look_hit_next    = look_hit_reg;
        hit_next         = hit_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        cur_z_next       = cur_z_reg;
        mag_next         = mag_reg;
        acc_next         = acc_reg;
        r2_next          = r2_reg;
        bin_hi_next      = bin_hi_reg;
        bin_next         = bin_reg;
        addr_next        = addr_reg;
        m_valid_next     = m_valid_reg;
        m_bin_count_next = m_bin_count_reg;
        m_sum_next       = m_sum_reg;
        m_bond_next      = m_bond_reg;
        m_frame_next     = m_frame_reg;

        if (cfg_we) begin
            unique case (cfg_index)
                CFG_BEADS_PER_CHAIN:  bpc_next = cfg_data[BPC_W-1:0];
                CFG_CHAINS_PER_FRAME: cpf_next = cfg_data[CPF_W-1:0];
                default: begin
                end
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT, ST_WIPE: begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cur_x_next    = s_pos_x;
                    cur_y_next    = s_pos_y;
                    cur_z_next    = s_pos_z;
                    axis_next     = AXIS_X;
                    acc_next      = '0;
                    look_hit_next = (s_func == FUNC_READ) && (idx_wide < IDX_LIMIT);
                    addr_next     = idx_wide[ADDR_W-1:0];
                    unique case (s_func)
                        FUNC_BEAD: begin
                            bead_next  = end_bead[BEAD_W-1:0];
                            chain_next = end_chain[CHAIN_W-1:0];
                            if (pos_first && frame_reg != '1) begin
                                frame_next = frame_reg + 1'b1;
                            end
                            // a chain opener has no bond, take its position now
                            if (!pos_bond) begin
                                prev_x_next = s_pos_x;
                                prev_y_next = s_pos_y;
                                prev_z_next = s_pos_z;
                            end
                        end
                        FUNC_CLEAR: begin
                            sum_next      = '0;
                            bond_next     = '0;
                            frame_next    = '0;
                            bead_next     = '0;
                            chain_next    = '0;
                            prev_x_next   = '0;
                            prev_y_next   = '0;
                            prev_z_next   = '0;
                            clr_addr_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIFF: begin
                mag_next = d_cp[COORD_W] ? d_pc[MUL_W-1:0] : d_cp[MUL_W-1:0];
            end
            ST_ACC: begin
                acc_next  = sat_add(acc_reg, product);
                axis_next = axis_reg + 1'b1;
            end
            ST_SCALE: begin
                r2_next = to_q32(acc_reg);
            end
            ST_BIN_HI: begin
                sum_next = sat_add(sum_reg, r2_reg);
                if (bond_reg != '1) begin
                    bond_next = bond_reg + 1'b1;
                end
            end
            ST_BIN_LO: begin
                // integer part times 100
                bin_hi_next = product[BIN_W-1:0];
            end
            ST_BIN_SUM: begin
                // plus the whole part of fraction times 100
                bin_next = bin_hi_reg + BIN_W'(product[PROD_W-1:MUL_W]);
            end
            ST_INC_RD: begin
                // a saturated length lands in no bin
                hit_next = (r2_reg != '1) && (bin_reg < BIN_LIMIT);
            end
            ST_INC_WR: begin
                prev_x_next = cur_x_reg;
                prev_y_next = cur_y_reg;
                prev_z_next = cur_z_reg;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_bin_count_next = look_hit_reg ? hist_rdata : '0;
                    m_sum_next       = sum_reg;
                    m_bond_next      = bond_reg;
                    m_frame_next     = frame_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            bpc_reg      <= BPC_MIN;
            cpf_reg      <= CPF_W'(1);
            bead_reg     <= '0;
            chain_reg    <= '0;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            prev_z_reg   <= '0;
            sum_reg      <= '0;
            bond_reg     <= '0;
            frame_reg    <= '0;
            clr_addr_reg <= '0;
            axis_reg     <= AXIS_X;
            look_hit_reg <= 1'b0;
            hit_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            bpc_reg      <= bpc_next;
            cpf_reg      <= cpf_next;
            bead_reg     <= bead_next;
            chain_reg    <= chain_next;
            prev_x_reg   <= prev_x_next;
            prev_y_reg   <= prev_y_next;
            prev_z_reg   <= prev_z_next;
            sum_reg      <= sum_next;
            bond_reg     <= bond_next;
            frame_reg    <= frame_next;
            clr_addr_reg <= clr_addr_next;
            axis_reg     <= axis_next;
            look_hit_reg <= look_hit_next;
            hit_reg      <= hit_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        cur_x_reg       <= cur_x_next;
        cur_y_reg       <= cur_y_next;
        cur_z_reg       <= cur_z_next;
        mag_reg         <= mag_next;
        acc_reg         <= acc_next;
        r2_reg          <= r2_next;
        bin_hi_reg      <= bin_hi_next;
        bin_reg         <= bin_next;
        addr_reg        <= addr_next;
        m_bin_count_reg <= m_bin_count_next;
        m_sum_reg       <= m_sum_next;
        m_bond_reg      <= m_bond_next;
        m_frame_reg     <= m_frame_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_bin_count     = m_bin_count_reg;
    assign m_sum_sq_length = m_sum_reg;
    assign m_bond_total    = m_bond_reg;
    assign m_frame_total   = m_frame_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // a result only appears after the final state loaded it
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the final state");

    // a bond only ever increments a bin inside the histogram
    a_bin_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (hist_we && state_reg == ST_INC_WR) |-> (bin_reg < BIN_LIMIT))
        else $error("histogram increment beyond last bin");

    // no request is taken while the memory sweep runs
    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INIT || state_reg == ST_WIPE) |-> !s_ready)
        else $error("request accepted during histogram sweep");

    // a completed bond adds exactly one to the bond total unless saturated
    a_bond_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BIN_HI && bond_reg != '1) |=> (bond_reg == $past(bond_reg) + 1'b1))
        else $error("bond total did not advance");

endmodule

`default_nettype wire

// ----- hdl/blh_hist_ram.sv -----
`default_nettype none

module blh_hist_ram #(
    parameter int DEPTH  = 201,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 32
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/blh_mul.sv -----
`default_nettype none

module blh_mul
    import blh_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [MUL_W-1:0]  op_a,
    input  wire logic [MUL_W-1:0]  op_b,
    output logic      [PROD_W-1:0] product
);

    logic [PROD_W-1:0] product_reg;

    // one registered 32x32 unsigned product
    always_ff @(posedge aclk) begin
        if (en) begin
            product_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
    end

    assign product = product_reg;

endmodule

`default_nettype wire
